// ----- src/modbus_response_deframer_defines.svh -----
// Assertion macros used by the port-level checker of the response deframer.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef MODBUS_RESPONSE_DEFRAMER_DEFINES_SVH
`define MODBUS_RESPONSE_DEFRAMER_DEFINES_SVH
// Same-cycle implication.
`define MRD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");
// Next-cycle implication.
`define MRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");
`endif

// ----- src/mrd_pkg.sv -----
// Types, codes and CRC helper for the response deframer.
// Depends on nothing.
`default_nettype none
package mrd_pkg;
  typedef struct packed {
    logic       is_read;
    logic [7:0] data;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDWAIT, ST_SCHK, ST_SFUNC, ST_SHI, ST_SLO, ST_SBC,
    ST_SLEN, ST_SCRC, ST_SW0, ST_SW1, ST_DROP, ST_DONE
  } eng_state_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam int          EXC_BIT  = 7;
  localparam logic [7:0]  FC_READ_FIRST  = 8'h01;
  localparam logic [7:0]  FC_READ_LAST   = 8'h04;
  localparam logic [7:0]  FC_WRITE_COIL  = 8'h05;
  localparam logic [7:0]  FC_WRITE_REG   = 8'h06;
  localparam logic [7:0]  FC_WRITE_COILS = 8'h0F;
  localparam logic [7:0]  FC_WRITE_REGS  = 8'h10;
  localparam logic [8:0]  RTU_FC_OFF = 9'd1;
  localparam logic [8:0]  RTU_BC_OFF = 9'd2;
  localparam logic [8:0]  TCP_FC_OFF = 9'd7;
  localparam logic [8:0]  TCP_LHI_OFF = 9'd4;
  localparam logic [8:0]  TCP_LLO_OFF = 9'd5;
  localparam logic [16:0] RTU_EXC_LEN = 17'd5;
  localparam logic [16:0] TCP_EXC_LEN = 17'd9;
  localparam logic [16:0] RTU_RD_HDR  = 17'd5;
  localparam logic [16:0] RTU_WR_LEN  = 17'd8;
  localparam logic [16:0] TCP_HDR     = 17'd6;
  localparam logic [15:0] TCP_MIN_FIELD = 16'd2;
  localparam int          RTU_MIN_FILL = 4;
  localparam int          TCP_MIN_FILL = 8;
  localparam logic [1:0]  REG_TCP_MODE = 2'd0;

  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- src/mrd_front.sv -----
// Front end: two-word input queue that tags each word as a read or a push.
// Depends on mrd_pkg.
`default_nettype none
module mrd_front import mrd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic       in_action,
  input  wire logic [7:0] in_rx_byte,
  output logic            item_valid,
  output item_t           item,
  input  wire logic       item_take
);
  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign full       = (cnt_r == 2'd2);
  assign item_valid = (cnt_r != 2'd0);
  assign item       = q_r[rp_r];
  assign wr         = push && !full;
  assign rd         = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= '{is_read: in_action, data: in_rx_byte};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ----- src/mrd_engine.sv -----
// Back end: byte buffer, frame search sequencer with CRC check, result register.
// Depends on mrd_pkg.
`default_nettype none
module mrd_engine import mrd_pkg::*; #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        tcp_mode,
  input  wire logic        item_valid,
  input  item_t            item,
  output logic             item_take,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_frame_ready,
  output logic [8:0]       out_frame_length,
  output logic [7:0]       out_out_byte,
  output logic             out_last_byte,
  output logic             out_overflow,
  output logic [15:0]      out_hunt_count
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int FW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = ((AW > 9) ? AW : 9) + 1;
  localparam int FRAME_MAX = (BUFFER_BYTES < 511) ? BUFFER_BYTES : 511;
  localparam logic [16:0] FRAME_MAX_L = 17'(FRAME_MAX);
  localparam logic [SW-1:0] BUF_S = SW'(BUFFER_BYTES);
  localparam logic [FW-1:0] BUF_F = FW'(BUFFER_BYTES);

  logic [7:0]    mem [BUFFER_BYTES];
  logic [7:0]    rd_data_r;
  eng_state_t    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [8:0]    pend_r, pend_nxt, ro_r, ro_nxt, idx_r, idx_nxt;
  logic [15:0]   hunt_r, hunt_nxt, crc_r, crc_nxt;
  logic [16:0]   exp_r, exp_nxt;
  logic [7:0]    hi_r, hi_nxt, wlo_r, wlo_nxt, obyte_r, obyte_nxt;
  logic          last_r, last_nxt, ovf_r, ovf_nxt;
  logic          ov_r, ov_nxt;
  logic          o_ready_r, o_last_r, o_ovf_r;
  logic [8:0]    o_len_r;
  logic [7:0]    o_byte_r;
  logic [15:0]   o_hunt_r;
  logic          load;

  logic [8:0]    rd_off;
  logic [SW-1:0] rd_sum, wr_sum, adv_sum, adv_amt;
  logic [AW-1:0] rd_addr, wr_addr, adv_head;
  logic          wr_en;
  logic [16:0]   fill_e;
  logic [15:0]   field;

  assign fill_e = {{(17-FW){1'b0}}, fill_r};
  assign field  = {hi_r, rd_data_r};

  always_comb begin
    rd_sum  = SW'(head_r) + SW'(rd_off);
    if (rd_sum >= BUF_S) rd_sum = rd_sum - BUF_S;
    rd_addr = rd_sum[AW-1:0];
    wr_sum  = SW'(head_r) + SW'(fill_r);
    if (wr_sum >= BUF_S) wr_sum = wr_sum - BUF_S;
    wr_addr = wr_sum[AW-1:0];
    adv_sum = SW'(head_r) + adv_amt;
    if (adv_sum >= BUF_S) adv_sum = adv_sum - BUF_S;
    adv_head = adv_sum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= item.data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    pend_nxt  = pend_r;
    ro_nxt    = ro_r;
    idx_nxt   = idx_r;
    hunt_nxt  = hunt_r;
    crc_nxt   = crc_r;
    exp_nxt   = exp_r;
    hi_nxt    = hi_r;
    wlo_nxt   = wlo_r;
    obyte_nxt = obyte_r;
    last_nxt  = last_r;
    ovf_nxt   = ovf_r;
    rd_off    = 9'd0;
    adv_amt   = '0;
    wr_en     = 1'b0;
    item_take = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          obyte_nxt = 8'd0;
          last_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_SCHK;
          if (!item.is_read) begin
            if (fill_r < BUF_F) begin
              wr_en    = 1'b1;
              fill_nxt = fill_r + FW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (pend_r != 9'd0) begin
            rd_off    = ro_r;
            state_nxt = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: begin
        obyte_nxt = rd_data_r;
        if ({1'b0, ro_r} + 10'd1 >= {1'b0, pend_r}) begin
          last_nxt  = 1'b1;
          adv_amt   = SW'(pend_r);
          head_nxt  = adv_head;
          fill_nxt  = fill_r - FW'(pend_r);
          pend_nxt  = 9'd0;
          ro_nxt    = 9'd0;
        end else begin
          ro_nxt = ro_r + 9'd1;
        end
        state_nxt = ST_SCHK;
      end
      ST_SCHK: begin
        if (pend_r != 9'd0) begin
          state_nxt = ST_DONE;
        end else if (fill_r < (tcp_mode ? FW'(TCP_MIN_FILL) : FW'(RTU_MIN_FILL))) begin
          state_nxt = ST_DONE;
        end else begin
          rd_off    = tcp_mode ? TCP_FC_OFF : RTU_FC_OFF;
          state_nxt = ST_SFUNC;
        end
      end
      ST_SFUNC: begin
        if (rd_data_r[EXC_BIT]) begin
          exp_nxt   = tcp_mode ? TCP_EXC_LEN : RTU_EXC_LEN;
          state_nxt = ST_SLEN;
        end else if (tcp_mode) begin
          rd_off    = TCP_LHI_OFF;
          state_nxt = ST_SHI;
        end else if (rd_data_r inside {[FC_READ_FIRST:FC_READ_LAST]}) begin
          rd_off    = RTU_BC_OFF;
          state_nxt = ST_SBC;
        end else if (rd_data_r inside {FC_WRITE_COIL, FC_WRITE_REG,
                                       FC_WRITE_COILS, FC_WRITE_REGS}) begin
          exp_nxt   = RTU_WR_LEN;
          state_nxt = ST_SLEN;
        end else begin
          state_nxt = ST_DROP;
        end
      end
      ST_SHI: begin
        hi_nxt    = rd_data_r;
        rd_off    = TCP_LLO_OFF;
        state_nxt = ST_SLO;
      end
      ST_SLO: begin
        if (field < TCP_MIN_FIELD) begin
          state_nxt = ST_DROP;
        end else begin
          exp_nxt   = TCP_HDR + {1'b0, field};
          state_nxt = ST_SLEN;
        end
      end
      ST_SBC: begin
        exp_nxt   = RTU_RD_HDR + {9'd0, rd_data_r};
        state_nxt = ST_SLEN;
      end
      ST_SLEN: begin
        if (exp_r > FRAME_MAX_L) begin
          state_nxt = ST_DROP;
        end else if (fill_e < exp_r) begin
          state_nxt = ST_DONE;
        end else if (tcp_mode) begin
          pend_nxt  = exp_r[8:0];
          ro_nxt    = 9'd0;
          state_nxt = ST_DONE;
        end else begin
          crc_nxt   = CRC_INIT;
          idx_nxt   = 9'd0;
          rd_off    = 9'd0;
          state_nxt = ST_SCRC;
        end
      end
      ST_SCRC: begin
        crc_nxt = crc_update(crc_r, rd_data_r);
        if (idx_r + 9'd1 == exp_r[8:0] - 9'd2) begin
          rd_off    = exp_r[8:0] - 9'd2;
          state_nxt = ST_SW0;
        end else begin
          idx_nxt = idx_r + 9'd1;
          rd_off  = idx_r + 9'd1;
        end
      end
      ST_SW0: begin
        wlo_nxt   = rd_data_r;
        rd_off    = exp_r[8:0] - 9'd1;
        state_nxt = ST_SW1;
      end
      ST_SW1: begin
        if (crc_r == {rd_data_r, wlo_r}) begin
          pend_nxt  = exp_r[8:0];
          ro_nxt    = 9'd0;
          state_nxt = ST_DONE;
        end else begin
          if (hunt_r != 16'hFFFF) hunt_nxt = hunt_r + 16'd1;
          state_nxt = ST_DROP;
        end
      end
      ST_DROP: begin
        adv_amt   = SW'(1);
        head_nxt  = adv_head;
        fill_nxt  = fill_r - FW'(1);
        state_nxt = ST_SCHK;
      end
      ST_DONE: begin
        if (!ov_r || pop) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (pop && ov_r) ov_nxt = 1'b0;
    if (load) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    crc_r   <= crc_nxt;
    exp_r   <= exp_nxt;
    hi_r    <= hi_nxt;
    wlo_r   <= wlo_nxt;
    obyte_r <= obyte_nxt;
    last_r  <= last_nxt;
    ovf_r   <= ovf_nxt;
    if (load) begin
      o_ready_r <= (pend_r != 9'd0);
      o_len_r   <= pend_r;
      o_byte_r  <= obyte_r;
      o_last_r  <= last_r;
      o_ovf_r   <= ovf_r;
      o_hunt_r  <= hunt_r;
    end
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      fill_r  <= '0;
      pend_r  <= 9'd0;
      ro_r    <= 9'd0;
      hunt_r  <= 16'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      ro_r    <= ro_nxt;
      hunt_r  <= hunt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign empty            = !ov_r;
  assign out_frame_ready  = o_ready_r;
  assign out_frame_length = o_len_r;
  assign out_out_byte     = o_byte_r;
  assign out_last_byte    = o_last_r;
  assign out_overflow     = o_ovf_r;
  assign out_hunt_count   = o_hunt_r;
endmodule
`default_nettype wire

// ----- src/modbus_response_deframer.sv -----
// Top level of the Modbus response deframer: configuration register and wiring.
// Depends on mrd_pkg, mrd_front and mrd_engine.
//
//   Channel   Ports                          Handshake
//   input     in_action, in_rx_byte          push / full
//   result    out_frame_ready .. hunt_count  empty / pop
//   config    paddr, pwdata, prdata          psel, penable, pwrite, pready
//
// A push and a read of a waiting frame are each followed by the frame search.
// Each search attempt walks the header states, and an RTU attempt that
// reaches the CRC reads each frame byte in turn through the single buffer read port.
// Every dropped byte starts a new attempt, so a resync costs one attempt per byte.
// Reset is synchronous; the buffer needs no clearing.
// A two-word input queue accepts words until full while a result waits for pop.
`default_nettype none
module modbus_response_deframer import mrd_pkg::*; #(
  parameter int BUFFER_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_rx_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_frame_ready,
  output logic [8:0]       out_frame_length,
  output logic [7:0]       out_out_byte,
  output logic             out_last_byte,
  output logic             out_overflow,
  output logic [15:0]      out_hunt_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic  tcp_mode_r;
  logic  item_valid, item_take;
  item_t item;
  logic  reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TCP_MODE[0]) && (paddr[1:0] == 2'b00);
  assign prdata  = reg_hit ? {31'd0, tcp_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcp_mode_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tcp_mode_r <= pwdata[0];
    end
  end

  mrd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_action  (in_action),
    .in_rx_byte (in_rx_byte),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  mrd_engine #(.BUFFER_BYTES(BUFFER_BYTES)) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .tcp_mode         (tcp_mode_r),
    .item_valid       (item_valid),
    .item             (item),
    .item_take        (item_take),
    .empty            (empty),
    .pop              (pop),
    .out_frame_ready  (out_frame_ready),
    .out_frame_length (out_frame_length),
    .out_out_byte     (out_out_byte),
    .out_last_byte    (out_last_byte),
    .out_overflow     (out_overflow),
    .out_hunt_count   (out_hunt_count)
  );
endmodule
`default_nettype wire

// ----- src/mrd_checker.sv -----
// Port-level checker for the response deframer, bound to its top level.
// Depends on modbus_response_deframer_defines.svh.
`default_nettype none
`include "modbus_response_deframer_defines.svh"
module mrd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic       out_frame_ready,
  input wire logic [8:0] out_frame_length,
  input wire logic       out_last_byte,
  input wire logic       out_overflow
);
  `MRD_ASSERT_NOW(a_ready_len, !empty, out_frame_ready == (out_frame_length != 9'd0))
  `MRD_ASSERT_NOW(a_last_not_ovf, !empty && out_last_byte, !out_overflow)
  `MRD_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_frame_length))
endmodule

bind modbus_response_deframer mrd_checker u_mrd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .empty            (empty),
  .pop              (pop),
  .out_frame_ready  (out_frame_ready),
  .out_frame_length (out_frame_length),
  .out_last_byte    (out_last_byte),
  .out_overflow     (out_overflow)
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for modbus_response_deframer: random and directed
// RTU/TCP byte streams, checked word by word against a scoreboard predictor.
// Depends on mrd_pkg and the deframer RTL.
module tb_top;
  import mrd_pkg::*;

  localparam int STORE_BYTES = 256;
  localparam int FRAME_LIMIT = 256;
  localparam int IDLE_LIMIT  = 400000;
  localparam int PHASE_WORDS = 500;
  localparam logic [2:0] ADDR_TCP_MODE = {REG_TCP_MODE[0], 2'b00};
  localparam bit ACT_PUSH = 1'b0;
  localparam bit ACT_READ = 1'b1;

  typedef enum int {CUT_WAIT, CUT_DROP, CUT_FOUND} cut_t;

  typedef struct {
    bit        ready;
    bit [8:0]  length;
    bit [7:0]  data;
    bit        last;
    bit        ovf;
    bit [15:0] hunt;
  } resp_t;

  function automatic bit [15:0] crc_byte(bit [15:0] crc, bit [7:0] b);
    crc ^= {8'h00, b};
    for (int i = 0; i < 8; i++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    return crc;
  endfunction

  class deframer_scoreboard;
    bit [7:0]    store[STORE_BYTES];
    int unsigned head, fill, frame_len, rd_off;
    bit [15:0]   hunt;
    bit          tcp;
    resp_t       expected_q[$];
    int          errors;

    function bit [7:0] byte_at(int unsigned i);
      return store[(head + i) % STORE_BYTES];
    endfunction

    function void discard(int unsigned n);
      if (n > fill) n = fill;
      head = (head + n) % STORE_BYTES;
      fill -= n;
    endfunction

    function cut_t try_cut();
      bit [7:0]    fc;
      int unsigned need;
      int unsigned field;
      bit [15:0]   crc;
      if (fill < (tcp ? 8 : 4)) return CUT_WAIT;
      fc = byte_at(tcp ? 7 : 1);
      if (fc[7]) begin
        need = tcp ? 9 : 5;
      end else if (tcp) begin
        field = {byte_at(4), byte_at(5)};
        if (field < 2) return CUT_DROP;
        need = 6 + field;
      end else if (fc >= FC_READ_FIRST && fc <= FC_READ_LAST) begin
        need = 5 + byte_at(2);
      end else if (fc == FC_WRITE_COIL || fc == FC_WRITE_REG || fc == FC_WRITE_COILS
                   || fc == FC_WRITE_REGS) begin
        need = 8;
      end else begin
        return CUT_DROP;
      end
      if (need > FRAME_LIMIT) return CUT_DROP;
      if (fill < need) return CUT_WAIT;
      if (!tcp) begin
        crc = 16'hFFFF;
        for (int unsigned i = 0; i + 2 < need; i++) crc = crc_byte(crc, byte_at(i));
        if (crc != {byte_at(need - 1), byte_at(need - 2)}) begin
          if (hunt != 16'hFFFF) hunt++;
          return CUT_DROP;
        end
      end
      frame_len = need;
      rd_off = 0;
      return CUT_FOUND;
    endfunction

    function void note_word(bit act, bit [7:0] b);
      resp_t r;
      cut_t  c;
      r = '{default: 0};
      if (act == ACT_PUSH) begin
        if (fill < STORE_BYTES) begin
          store[(head + fill) % STORE_BYTES] = b;
          fill++;
        end else begin
          r.ovf = 1;
        end
      end else if (frame_len != 0) begin
        r.data = byte_at(rd_off);
        if (rd_off + 1 >= frame_len) begin
          r.last = 1;
          discard(frame_len);
          frame_len = 0;
          rd_off = 0;
        end else begin
          rd_off++;
        end
      end
      if (frame_len == 0) begin
        c = try_cut();
        while (c == CUT_DROP) begin
          discard(1);
          c = try_cut();
        end
      end
      r.ready = frame_len != 0;
      r.length = frame_len[8:0];
      r.hunt = hunt;
      expected_q.push_back(r);
    endfunction

    function void check_word(resp_t got);
      resp_t e;
      if (expected_q.size() == 0) begin
        $error("Result word arrived with nothing expected.");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.ready !== e.ready) begin
        $error("frame_ready: expected %0d, got %0d", e.ready, got.ready); errors++;
      end
      if (got.length !== e.length) begin
        $error("frame_length: expected %0d, got %0d", e.length, got.length); errors++;
      end
      if (got.data !== e.data) begin
        $error("out_byte: expected %0h, got %0h", e.data, got.data); errors++;
      end
      if (got.last !== e.last) begin
        $error("last_byte: expected %0d, got %0d", e.last, got.last); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow: expected %0d, got %0d", e.ovf, got.ovf); errors++;
      end
      if (got.hunt !== e.hunt) begin
        $error("hunt_count: expected %0d, got %0d", e.hunt, got.hunt); errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n, push, full, in_action, empty, pop;
  logic [7:0]  in_rx_byte;
  logic        out_frame_ready, out_last_byte, out_overflow;
  logic [8:0]  out_frame_length;
  logic [7:0]  out_out_byte;
  logic [15:0] out_hunt_count;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  deframer_scoreboard sb;
  bit steady;
  int words_sent;
  int idle_cycles;

  modbus_response_deframer uut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(bit act, bit [7:0] b);
    int g;
    @(negedge clk);
    push <= 1;
    in_action <= act;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    sb.note_word(act, b);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk);
      push <= 0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic push_frame(bit [7:0] f[$]);
    foreach (f[i]) send_word(ACT_PUSH, f[i]);
  endtask

  task automatic read_frame();
    while (sb.frame_len != 0) send_word(ACT_READ, $urandom_range(0, 255));
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    drain();
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= ADDR_TCP_MODE; pwdata <= {31'd0, m};
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.tcp = m;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic void add_crc(ref bit [7:0] f[$]);
    bit [15:0] crc;
    crc = 16'hFFFF;
    foreach (f[i]) crc = crc_byte(crc, f[i]);
    f.push_back(crc[7:0]);
    f.push_back(crc[15:8]);
  endfunction

  function automatic void make_frame(bit tcp, ref bit [7:0] f[$]);
    int k, n;
    bit [7:0] codes[4] = '{FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS};
    f.delete();
    k = $urandom_range(0, 2);
    if (!tcp) begin
      f.push_back($urandom_range(0, 255));
      if (k == 0) begin
        f.push_back($urandom_range(8'h80, 8'hFF));
        f.push_back($urandom_range(0, 255));
      end else if (k == 1) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 251) : $urandom_range(0, 16);
        f.push_back($urandom_range(1, 4));
        f.push_back(n);
        repeat (n) f.push_back($urandom_range(0, 255));
      end else begin
        f.push_back(codes[$urandom_range(0, 3)]);
        repeat (4) f.push_back($urandom_range(0, 255));
      end
      add_crc(f);
    end else begin
      repeat (4) f.push_back($urandom_range(0, 255));
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(2, 250) : $urandom_range(2, 20);
      f.push_back(n[15:8]);
      f.push_back(n[7:0]);
      f.push_back($urandom_range(0, 255));
      if (k == 0) begin
        f.push_back($urandom_range(8'h80, 8'hFF));
        f.push_back($urandom_range(0, 255));
      end else begin
        f.push_back($urandom_range(0, 8'h7F));
        repeat (n - 2) f.push_back($urandom_range(0, 255));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(0, f.size() - 1);
      f[n] ^= 8'h01 << $urandom_range(0, 7);
    end
  endfunction

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop <= 0;
        stall--;
      end else begin
        pop <= 1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty)
      sb.check_word('{out_frame_ready, out_frame_length, out_out_byte, out_last_byte,
                      out_overflow, out_hunt_count});
  end

  initial begin
    bit [7:0] f[$];
    sb = new();
    rst_n = 0; push = 0; pop = 0; in_action = 0; in_rx_byte = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    write_mode(0);
    send_word(ACT_READ, 8'hFF);
    f = '{8'h11, FC_WRITE_REG, 8'h00, 8'h01, 8'h00, 8'h03};
    add_crc(f); push_frame(f); read_frame();
    f = '{8'hFF, 8'h83, 8'h02};
    add_crc(f); push_frame(f); read_frame();
    f = '{8'h01, FC_READ_FIRST, 8'h00};
    add_crc(f); push_frame(f); read_frame();
    f = '{8'h01, 8'h07, 8'h00, 8'h00};
    push_frame(f);
    f = '{8'h01, FC_WRITE_REGS, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
    push_frame(f);
    f = '{8'h01, FC_READ_LAST, 8'd252, 8'h00};
    push_frame(f);
    f = '{8'h02, FC_WRITE_COILS, 8'h00, 8'h13, 8'h00, 8'h0A};
    add_crc(f); push_frame(f); read_frame();

    write_mode(1);
    f = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00};
    push_frame(f);
    f = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'd251, 8'h01, 8'h03};
    push_frame(f);
    f = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h84, 8'h04};
    push_frame(f); read_frame();
    f = '{8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'd250, 8'h01, 8'h03};
    repeat (248) f.push_back($urandom_range(0, 255));
    push_frame(f);
    repeat (3) send_word(ACT_PUSH, $urandom_range(0, 255));
    read_frame();

    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      steady = (ph == 2);
      words_sent = 0;
      while (words_sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 5)) send_word(ACT_PUSH, $urandom_range(0, 255));
        end else begin
          make_frame(sb.tcp, f);
          push_frame(f);
        end
        if ($urandom_range(0, 19) == 0) send_word(ACT_READ, $urandom_range(0, 255));
        if ($urandom_range(0, 9) < 7) read_frame();
      end
    end
    steady = 0;
    write_mode(0);

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
